### rtl/pba_pkg.sv
// shared types, codes and defaults for the page bitmap allocator
package pba_pkg;

	localparam int DEF_INT_PAGES_MAX = 64;
	localparam int DEF_EXT_PAGES_MAX = 32768;
	localparam int DEF_PAGE_SHIFT    = 12;

	localparam logic [2:0] KIND_RESERVE = 3'd0;
	localparam logic [2:0] KIND_RELEASE = 3'd1;
	localparam logic [2:0] KIND_TEST    = 3'd2;
	localparam logic [2:0] KIND_FIND    = 3'd3;
	localparam logic [2:0] KIND_XLATE   = 3'd4;

	localparam logic [1:0] MSEL_INT  = 2'd0;
	localparam logic [1:0] MSEL_EXT  = 2'd1;
	localparam logic [1:0] MSEL_BOTH = 2'd2;
	localparam logic [1:0] MSEL_NONE = 2'd3;

	localparam logic [1:0] REG_INT_BASE  = 2'd0;
	localparam logic [1:0] REG_INT_PAGES = 2'd1;
	localparam logic [1:0] REG_EXT_BASE  = 2'd2;
	localparam logic [1:0] REG_EXT_PAGES = 2'd3;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic mark_req;
		logic mark_fnd;
		logic mark_step;
		logic test_rd;
		logic scan_init;
		logic scan_mem;
		logic scan_step;
		logic capture;
	} pba_cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic       mark_done;
		logic       scan_done;
		logic       scan_found;
		logic       next_mem;
		logic       reserve;
		logic [2:0] kind;
	} pba_stat_t;

endpackage

### rtl/page_bitmap_allocator_core.sv
// top level of the page bitmap allocator
//
//  port group   dir  handshake           contents
//  request      in   in_valid/in_ready   kind, mem_select, page, count, align, reserve,
//                                        xlate_addr
//  result       out  out_valid/out_ready status, mem_result, page_result, address_result,
//                                        occupied, int_allocated, ext_allocated
//  config       in   cfg_we              cfg_index, cfg_data
//
// after reset a clearing pass zeroes both bitmaps; in_ready stays low meanwhile
// after decode, test, translate and unknown kinds go straight to the result handoff, while
// reserve and release first walk the pages in range
// find scans one page a cycle and goes on to the external bitmap when both are selected
// and the internal one holds no fit; when it reserves, it then marks the run it found
// the result register holds one beat; the next request is taken while it waits, and a
// finished request stalls at the handoff until out_ready frees the register
module page_bitmap_allocator_core import pba_pkg::*; #(
	parameter int INT_PAGES_MAX = DEF_INT_PAGES_MAX,
	parameter int EXT_PAGES_MAX = DEF_EXT_PAGES_MAX,
	parameter int PAGE_SHIFT    = DEF_PAGE_SHIFT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [1:0]  mem_select,
	input  logic [14:0] page,
	input  logic [15:0] count,
	input  logic        align,
	input  logic        reserve,
	input  logic [31:0] xlate_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic        mem_result,
	output logic [14:0] page_result,
	output logic [31:0] address_result,
	output logic        occupied,
	output logic [6:0]  int_allocated,
	output logic [15:0] ext_allocated
);

	pba_cmd_t  cmd;
	pba_stat_t stat;

	pba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pba_datapath #(
		.INT_PAGES_MAX (INT_PAGES_MAX),
		.EXT_PAGES_MAX (EXT_PAGES_MAX),
		.PAGE_SHIFT    (PAGE_SHIFT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.mem_select     (mem_select),
		.page           (page),
		.count          (count),
		.align          (align),
		.reserve        (reserve),
		.xlate_addr     (xlate_addr),
		.status         (status),
		.mem_result     (mem_result),
		.page_result    (page_result),
		.address_result (address_result),
		.occupied       (occupied),
		.int_allocated  (int_allocated),
		.ext_allocated  (ext_allocated)
	);

endmodule

### rtl/pba_datapath.sv
// bitmaps, counters, config registers, scan and mark cursors, result registers
module pba_datapath import pba_pkg::*; #(
	parameter int INT_PAGES_MAX = DEF_INT_PAGES_MAX,
	parameter int EXT_PAGES_MAX = DEF_EXT_PAGES_MAX,
	parameter int PAGE_SHIFT    = DEF_PAGE_SHIFT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pba_cmd_t    cmd,
	output pba_stat_t   stat,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [2:0]  kind,
	input  logic [1:0]  mem_select,
	input  logic [14:0] page,
	input  logic [15:0] count,
	input  logic        align,
	input  logic        reserve,
	input  logic [31:0] xlate_addr,
	output logic        status,
	output logic        mem_result,
	output logic [14:0] page_result,
	output logic [31:0] address_result,
	output logic        occupied,
	output logic [6:0]  int_allocated,
	output logic [15:0] ext_allocated
);

	localparam int MAXP = (INT_PAGES_MAX > EXT_PAGES_MAX) ? INT_PAGES_MAX : EXT_PAGES_MAX;
	localparam int LW0  = $clog2(MAXP + 1);
	localparam int LW   = ((LW0 > 17) ? LW0 : 17) + 1;
	localparam int IAW  = (INT_PAGES_MAX > 1) ? $clog2(INT_PAGES_MAX) : 1;
	localparam int EAW  = (EXT_PAGES_MAX > 1) ? $clog2(EXT_PAGES_MAX) : 1;
	localparam int CIW  = $clog2(INT_PAGES_MAX + 1);
	localparam int CEW  = $clog2(EXT_PAGES_MAX + 1);

	logic [31:0] int_base_q, ext_base_q;
	logic [6:0]  int_pages_q;
	logic [15:0] ext_pages_q;

	logic [2:0]  kind_q;
	logic [1:0]  msel_q;
	logic [14:0] page_q;
	logic [15:0] count_q;
	logic        align_q, reserve_q;
	logic [31:0] addr_q;

	logic          int_mem [INT_PAGES_MAX];
	logic          ext_mem [EXT_PAGES_MAX];
	logic          int_rdata_q, ext_rdata_q;
	logic [CIW-1:0] int_cnt_q;
	logic [CEW-1:0] ext_cnt_q;

	logic [LW-1:0] clr_q, cur_q, end_q, rd_q, ev_q, start_q;
	logic          evv_q, found_q, mem_q;
	logic [15:0]   run_q, phase_q;

	logic [LW-1:0] lim0, lim1, lim_m, lim_s, first, span_end, ra;
	logic [LW-1:0] page_x;
	logic          set_bit, bit_rd, cond, hit, bad_find;
	logic          int_we, ext_we, wd, int_re, ext_re;
	logic [LW-1:0] wa;
	logic [31:0]   d_int, d_ext;
	logic          in_int, in_ext;

	// usable page counts
	assign lim0 = (LW'(int_pages_q) < LW'(INT_PAGES_MAX)) ? LW'(int_pages_q)
		: LW'(INT_PAGES_MAX);
	assign lim1 = (LW'(ext_pages_q) < LW'(EXT_PAGES_MAX)) ? LW'(ext_pages_q)
		: LW'(EXT_PAGES_MAX);
	assign lim_m  = mem_q ? lim1 : lim0;
	// bound of the memory the mark walk is about to enter
	assign lim_s  = cmd.mark_req ? (msel_q[0] ? lim1 : lim0) : lim_m;
	assign page_x = LW'(page_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_base_q  <= '0;
			int_pages_q <= 7'd64;
			ext_base_q  <= '0;
			ext_pages_q <= 16'd32768;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INT_BASE:  int_base_q  <= cfg_data;
				REG_INT_PAGES: int_pages_q <= cfg_data[6:0];
				REG_EXT_BASE:  ext_base_q  <= cfg_data;
				REG_EXT_PAGES: ext_pages_q <= cfg_data[15:0];
				default:       int_base_q  <= int_base_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind;
			msel_q    <= mem_select;
			page_q    <= page;
			count_q   <= count;
			align_q   <= align;
			reserve_q <= reserve;
			addr_q    <= xlate_addr;
		end
	end

	// mark run bounds
	always_comb begin
		if (cmd.mark_fnd) first = start_q;
		else first = page_x;
		span_end = first + LW'(count_q);
	end

	assign set_bit = (kind_q != KIND_RELEASE);

	// scan evaluation of the page whose bit came back this cycle
	assign bit_rd   = mem_q ? ext_rdata_q : int_rdata_q;
	assign cond     = !bit_rd && (!align_q || run_q != 16'd0 || phase_q == 16'd0);
	assign hit      = evv_q && !found_q && cond && (17'(run_q) + 17'd1 == 17'(count_q));
	assign bad_find = (count_q == 16'd0) || (msel_q == MSEL_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			int_cnt_q <= '0;
			ext_cnt_q <= '0;
			found_q   <= 1'b0;
			evv_q     <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + LW'(1);
			if (cmd.mark_step) begin
				if (!mem_q) begin
					if (set_bit) begin
						if (int_cnt_q < CIW'(INT_PAGES_MAX)) int_cnt_q <= int_cnt_q + CIW'(1);
					end else if (int_cnt_q != '0) begin
						int_cnt_q <= int_cnt_q - CIW'(1);
					end
				end else begin
					if (set_bit) begin
						if (ext_cnt_q < CEW'(EXT_PAGES_MAX)) ext_cnt_q <= ext_cnt_q + CEW'(1);
					end else if (ext_cnt_q != '0) begin
						ext_cnt_q <= ext_cnt_q - CEW'(1);
					end
				end
			end
			if (cmd.scan_init) begin
				found_q <= 1'b0;
				evv_q   <= 1'b0;
			end else if (cmd.scan_step && !found_q) begin
				evv_q <= (rd_q < lim_m);
				if (hit) found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mark_req || cmd.mark_fnd) begin
			cur_q <= first;
			if (cmd.mark_req && msel_q[1]) end_q <= '0;
			else if (span_end > lim_s) end_q <= lim_s;
			else end_q <= span_end;
		end else if (cmd.mark_step) begin
			cur_q <= cur_q + LW'(1);
		end
		if (cmd.mark_req) mem_q <= msel_q[0];
		if (cmd.scan_init) begin
			// second pass always goes to external, first pass follows the select
			mem_q   <= cmd.scan_mem || (msel_q == MSEL_EXT);
			rd_q    <= '0;
			run_q   <= '0;
			phase_q <= '0;
		end else if (cmd.scan_step && !found_q) begin
			if (rd_q < lim_m) begin
				ev_q <= rd_q;
				rd_q <= rd_q + LW'(1);
			end
			if (evv_q) begin
				phase_q <= (17'(phase_q) + 17'd1 == 17'(count_q)) ? 16'd0 : phase_q + 16'd1;
				if (cond) run_q <= run_q + 16'd1;
				else run_q <= '0;
				if (hit) start_q <= ev_q + LW'(1) - LW'(count_q);
			end
		end
	end

	// memory ports
	always_comb begin
		if (cmd.clr_step) begin
			wa     = clr_q;
			wd     = 1'b0;
			int_we = clr_q < LW'(INT_PAGES_MAX);
			ext_we = clr_q < LW'(EXT_PAGES_MAX);
		end else begin
			wa     = cur_q;
			wd     = set_bit;
			int_we = cmd.mark_step && !mem_q;
			ext_we = cmd.mark_step && mem_q;
		end
		if (cmd.test_rd) begin
			ra     = page_x;
			int_re = (page_x < LW'(INT_PAGES_MAX));
			ext_re = (page_x < LW'(EXT_PAGES_MAX));
		end else begin
			ra     = rd_q;
			int_re = cmd.scan_step && !found_q && !mem_q && (rd_q < lim_m);
			ext_re = cmd.scan_step && !found_q && mem_q && (rd_q < lim_m);
		end
	end

	always_ff @(posedge clk) begin
		if (int_we) int_mem[wa[IAW-1:0]] <= wd;
		if (int_re) int_rdata_q <= int_mem[ra[IAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ext_we) ext_mem[wa[EAW-1:0]] <= wd;
		if (ext_re) ext_rdata_q <= ext_mem[ra[EAW-1:0]];
	end

	// address translation
	assign d_int  = addr_q - int_base_q;
	assign d_ext  = addr_q - ext_base_q;
	assign in_int = (addr_q >= int_base_q) && ((d_int >> PAGE_SHIFT) < 32'(lim0));
	assign in_ext = (addr_q >= ext_base_q) && ((d_ext >> PAGE_SHIFT) < 32'(lim1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			status         <= 1'b0;
			mem_result     <= 1'b0;
			page_result    <= '0;
			address_result <= '0;
			occupied       <= 1'b0;
			int_allocated  <= 7'(int_cnt_q);
			ext_allocated  <= 16'(ext_cnt_q);
			case (kind_q)
				KIND_RESERVE, KIND_RELEASE: status <= 1'b0;
				KIND_TEST: begin
					occupied <= ((msel_q == MSEL_INT) && (page_x < lim0) && int_rdata_q)
						|| ((msel_q == MSEL_EXT) && (page_x < lim1) && ext_rdata_q);
				end
				KIND_FIND: begin
					status <= !found_q;
					if (found_q) begin
						mem_result     <= mem_q;
						page_result    <= 15'(start_q);
						address_result <= (mem_q ? ext_base_q : int_base_q)
							+ (32'(start_q) << PAGE_SHIFT);
					end
				end
				KIND_XLATE: begin
					if (in_int) begin
						page_result <= 15'(d_int >> PAGE_SHIFT);
					end else if (in_ext) begin
						mem_result  <= 1'b1;
						page_result <= 15'(d_ext >> PAGE_SHIFT);
					end else begin
						status <= 1'b1;
					end
				end
				default: status <= 1'b1;
			endcase
		end
	end

	assign stat.clr_done   = (clr_q == LW'(MAXP));
	assign stat.mark_done  = (cur_q >= end_q);
	assign stat.scan_done  = bad_find || (!evv_q && rd_q >= lim_m);
	assign stat.scan_found = found_q;
	assign stat.next_mem   = (msel_q == MSEL_BOTH) && !mem_q;
	assign stat.reserve    = reserve_q;
	assign stat.kind       = kind_q;

endmodule

### rtl/pba_ctrl.sv
// request sequencer: clearing pass, decode, mark walk, scan, result handoff
module pba_ctrl import pba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  pba_stat_t stat,
	output pba_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_DECODE = 6'b000100,
		ST_MARK   = 6'b001000,
		ST_SCAN   = 6'b010000,
		ST_FIN    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_done) state_d = ST_IDLE;
				else cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.kind)
					KIND_RESERVE, KIND_RELEASE: begin
						cmd.mark_req = 1'b1;
						state_d      = ST_MARK;
					end
					KIND_TEST: begin
						cmd.test_rd = 1'b1;
						state_d     = ST_FIN;
					end
					KIND_FIND: begin
						cmd.scan_init = 1'b1;
						cmd.scan_mem  = 1'b0;
						state_d       = ST_SCAN;
					end
					default: state_d = ST_FIN;
				endcase
			end
			ST_MARK: begin
				if (stat.mark_done) state_d = ST_FIN;
				else cmd.mark_step = 1'b1;
			end
			ST_SCAN: begin
				if (stat.scan_found) begin
					if (stat.reserve) begin
						cmd.mark_fnd = 1'b1;
						state_d      = ST_MARK;
					end else begin
						state_d = ST_FIN;
					end
				end else if (stat.scan_done) begin
					if (stat.next_mem) begin
						cmd.scan_init = 1'b1;
						cmd.scan_mem  = 1'b1;
					end else begin
						state_d = ST_FIN;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.capture = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
